// File: rtl/rrcp_pkg.sv
// rrcp_pkg: shared types and constants for the round-robin connection pool.
// Word layouts, operation and status codes, register indexes, state type.
// No dependencies.
`timescale 1ns / 1ps
package rrcp_pkg;

  localparam int HANDLE_W      = 16;
  localparam int TIME_W        = 48;
  localparam int TMO_W         = 26;
  localparam int MS_PER_SEC    = 1000;
  localparam int MAX_RESULTS   = 16;
  localparam int RES_IDX_W     = 4;
  localparam int FIELD_CNT_W   = 5;
  localparam int DEF_MAX_SLOTS = 16;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 16;

  localparam logic [1:0] OP_ACQUIRE = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_REMOVE  = 2'd2;
  localparam logic [1:0] OP_CLEANUP = 2'd3;

  localparam logic [3:0] ST_REUSED       = 4'd0;
  localparam logic [3:0] ST_CREATED      = 4'd1;
  localparam logic [3:0] ST_FULL         = 4'd2;
  localparam logic [3:0] ST_RELEASED     = 4'd3;
  localparam logic [3:0] ST_REL_MISS     = 4'd4;
  localparam logic [3:0] ST_REMOVED      = 4'd5;
  localparam logic [3:0] ST_REM_MISS     = 4'd6;
  localparam logic [3:0] ST_EXPIRED      = 4'd7;
  localparam logic [3:0] ST_NONE_EXPIRED = 4'd8;

  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_LIMIT   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IDLE_TIMEOUT = 1'd1;

  localparam logic [4:0]       RST_SIZE_LIMIT = 5'd16;
  localparam logic [TMO_W-1:0] RST_TMO_MS     = 26'd60000;

  typedef struct packed {
    logic [1:0]          operation;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   now_ms;
  } rrcp_in_t;

  typedef struct packed {
    logic [3:0]             status;
    logic [HANDLE_W-1:0]    result_handle;
    logic [FIELD_CNT_W-1:0] removed_count;
    logic [FIELD_CNT_W-1:0] busy_entries;
    logic [FIELD_CNT_W-1:0] held_entries;
    logic                   last;
  } rrcp_out_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   last_used;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_FIND, S_RDH, S_NEW, S_PASS, S_DONE, S_EMIT
  } state_t;

endpackage

// File: rtl/rrcp_mem.sv
// rrcp_mem: entry table memory, one write port, one registered read port.
// Holds handle and last-used time per slot. Uses rrcp_pkg.
`timescale 1ns / 1ps
module rrcp_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  rrcp_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output rrcp_pkg::entry_t rdata
);
  import rrcp_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/round_robin_connection_pool.sv
// round_robin_connection_pool: top level, control sequencer around the entry memory.
// Uses rrcp_pkg and rrcp_mem.
//
// channel  | handshake             | payload
// in       | in_valid / in_ready   | in_word (operation, handle, now_ms)
// out      | out_valid / out_ready | out_word (status, handle, counts, last)
// cfg      | cfg_we                | cfg_index, cfg_data
//
// One word at a time; N is the entry count when the word is taken.
// Acquire: an empty pool creates directly; else scan_start is reduced modulo N, then
// a busy scan. Release, remove, cleanup: one pass, one memory read per entry;
// remove and cleanup write compaction back behind the read pointer.
// Reset clears busy bits and counts at once; no clearing pass.
// out_ready low holds the result states; a finished word waits in the output register
// while the next input is taken.
`timescale 1ns / 1ps
module round_robin_connection_pool #(
  parameter int MAX_SLOTS = rrcp_pkg::DEF_MAX_SLOTS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  rrcp_pkg::rrcp_in_t                 in_word,
  output logic                               out_valid,
  input  logic                               out_ready,
  output rrcp_pkg::rrcp_out_t                out_word,
  input  logic                               cfg_we,
  input  logic [rrcp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rrcp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rrcp_pkg::*;

  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int LW = (CW > FIELD_CNT_W) ? CW : FIELD_CNT_W;

  state_t state, state_next;

  logic [4:0]          size_limit;
  logic [TMO_W-1:0]    tmo_ms;
  logic [MAX_SLOTS-1:0] busy;
  logic [CW-1:0]       cnt, active, rd, wr, removed;
  logic [IW-1:0]       scan_start, sidx, p_idx;
  logic [CW-1:0]       steps;
  logic                p_vld, found;
  logic [1:0]          cur_op;
  logic [HANDLE_W-1:0] cur_h;
  logic [TIME_W-1:0]   cur_now;
  logic [3:0]          res_status;
  logic [HANDLE_W-1:0] res_handle;
  logic [HANDLE_W-1:0] closed [MAX_RESULTS];
  logic [FIELD_CNT_W-1:0] k, nres;

  logic            mem_we;
  logic [IW-1:0]   mem_waddr, mem_raddr;
  entry_t          mem_wdata, mem_rdata;

  logic out_free, out_load, pass_end, rel_hit, del, below_limit, expired;

  rrcp_mem #(.DEPTH(MAX_SLOTS), .AW(IW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_free    = !out_valid || out_ready;
  assign out_load    = out_free && ((state == S_DONE) || (state == S_EMIT));
  assign pass_end    = (rd == cnt) && !p_vld;
  assign expired     = ({1'b0, cur_now} > ({1'b0, mem_rdata.last_used} +
                        (TIME_W + 1)'(tmo_ms)));
  assign rel_hit     = p_vld && !found && busy[p_idx] && (mem_rdata.handle == cur_h);
  assign del         = p_vld && ((cur_op == OP_REMOVE) ?
                        (!found && (mem_rdata.handle == cur_h)) :
                        (!busy[p_idx] && expired));
  assign below_limit = (LW'(cnt) < LW'(size_limit)) && (cnt < CW'(MAX_SLOTS));
  assign nres        = (LW'(removed) > LW'(MAX_RESULTS)) ? FIELD_CNT_W'(MAX_RESULTS)
                                                          : FIELD_CNT_W'(removed);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_word.operation == OP_ACQUIRE) begin
            state_next = (cnt == '0) ? S_NEW : S_MOD;
          end else begin
            state_next = S_PASS;
          end
        end
      end
      S_MOD: begin
        if (CW'(sidx) < cnt) state_next = S_FIND;
      end
      S_FIND: begin
        if (!busy[sidx]) state_next = S_RDH;
        else if (steps + 1'b1 == cnt) state_next = S_NEW;
      end
      S_RDH: state_next = S_DONE;
      S_NEW: state_next = S_DONE;
      S_PASS: begin
        if (pass_end) begin
          state_next = (cur_op == OP_CLEANUP && removed != '0) ? S_EMIT : S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      S_EMIT: begin
        if (out_free && (k + 1'b1 == nres)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    mem_we    = 1'b0;
    mem_waddr = p_idx;
    mem_wdata = '{handle: mem_rdata.handle, last_used: cur_now};
    mem_raddr = (state == S_PASS) ? rd[IW-1:0] : sidx;
    case (state)
      S_RDH: begin
        mem_we    = 1'b1;
        mem_waddr = sidx;
      end
      S_NEW: begin
        mem_we    = below_limit;
        mem_waddr = cnt[IW-1:0];
        mem_wdata = '{handle: cur_h, last_used: cur_now};
      end
      S_PASS: begin
        if (cur_op == OP_RELEASE) begin
          mem_we = rel_hit;
        end else begin
          mem_we    = p_vld && !del;
          mem_waddr = wr[IW-1:0];
          mem_wdata = mem_rdata;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      size_limit <= RST_SIZE_LIMIT;
      tmo_ms     <= RST_TMO_MS;
      busy       <= '0;
      cnt        <= '0;
      active     <= '0;
      scan_start <= '0;
      p_vld      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_SIZE_LIMIT:   size_limit <= cfg_data[4:0];
          REG_IDLE_TIMEOUT: tmo_ms     <= TMO_W'(cfg_data) * TMO_W'(MS_PER_SEC);
          default: ;
        endcase
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          cur_op  <= in_word.operation;
          cur_h   <= in_word.handle;
          cur_now <= in_word.now_ms;
          sidx    <= scan_start;
          steps   <= '0;
          rd      <= '0;
          wr      <= '0;
          removed <= '0;
          found   <= 1'b0;
          p_vld   <= 1'b0;
          k       <= '0;
        end
        S_MOD: begin
          if (CW'(sidx) >= cnt) sidx <= IW'(CW'(sidx) - cnt);
        end
        S_FIND: begin
          if (busy[sidx]) begin
            steps <= steps + 1'b1;
            sidx  <= (CW'(sidx) + 1'b1 == cnt) ? '0 : sidx + 1'b1;
          end
        end
        S_RDH: begin
          busy[sidx] <= 1'b1;
          active     <= active + 1'b1;
          scan_start <= (CW'(sidx) + 1'b1 == cnt) ? '0 : sidx + 1'b1;
          res_status <= ST_REUSED;
          res_handle <= mem_rdata.handle;
        end
        S_NEW: begin
          if (below_limit) begin
            busy[cnt[IW-1:0]] <= 1'b1;
            cnt        <= cnt + 1'b1;
            active     <= active + 1'b1;
            res_status <= ST_CREATED;
            res_handle <= cur_h;
          end else begin
            res_status <= ST_FULL;
            res_handle <= '0;
          end
        end
        S_PASS: begin
          if (rd < cnt) begin
            rd    <= rd + 1'b1;
            p_vld <= 1'b1;
            p_idx <= rd[IW-1:0];
          end else begin
            p_vld <= 1'b0;
          end
          if (cur_op == OP_RELEASE) begin
            if (rel_hit) begin
              busy[p_idx] <= 1'b0;
              active      <= active - 1'b1;
              found       <= 1'b1;
            end
          end else if (p_vld) begin
            if (del) begin
              found   <= 1'b1;
              removed <= removed + 1'b1;
              if (busy[p_idx]) active <= active - 1'b1;
              if (LW'(removed) < LW'(MAX_RESULTS)) begin
                closed[removed[RES_IDX_W-1:0]] <= mem_rdata.handle;
              end
            end else begin
              busy[wr[IW-1:0]] <= busy[p_idx];
              wr <= wr + 1'b1;
            end
          end
          if (pass_end) begin
            res_handle <= (cur_op == OP_CLEANUP) ? '0 : cur_h;
            case (cur_op)
              OP_RELEASE: res_status <= found ? ST_RELEASED : ST_REL_MISS;
              OP_REMOVE:  res_status <= found ? ST_REMOVED : ST_REM_MISS;
              default: begin
                res_status <= ST_NONE_EXPIRED;
                if (wr != '0) scan_start <= '0;
              end
            endcase
            if (cur_op != OP_RELEASE) begin
              cnt <= wr;
              for (int i = 0; i < MAX_SLOTS; i++) begin
                if (CW'(i) >= wr) busy[i] <= 1'b0;
              end
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_word  <= '{status: res_status, result_handle: res_handle,
                           removed_count: '0,
                           busy_entries: FIELD_CNT_W'(active),
                           held_entries: FIELD_CNT_W'(cnt), last: 1'b1};
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_word  <= '{status: ST_EXPIRED, result_handle: closed[k[RES_IDX_W-1:0]],
                           removed_count: k + 1'b1,
                           busy_entries: FIELD_CNT_W'(active),
                           held_entries: FIELD_CNT_W'(cnt),
                           last: (k + 1'b1 == nres)};
            k <= k + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_SLOTS)) else $error("entry count above slot count");

  a_active_bound: assert property (@(posedge clk) disable iff (rst)
    active <= cnt) else $error("busy count above entry count");

  a_busy_tail: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((busy >> cnt) == '0)) else $error("busy bit past table end");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (out_valid && out_word.last))
    else $error("single result without last");

endmodule
